// ===== design/bofh_pkg.sv =====
`default_nettype none

package bofh_pkg;

    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int SLOT_BITS  = 6;
    localparam int COUNT_BITS = 7;
    localparam int BND_BITS   = COORD_BITS + 4;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [SIZE_BITS-1:0]         size_t;
    typedef logic signed [BND_BITS-1:0]   bound_t;
    typedef logic [SLOT_BITS-1:0]         slot_t;
    typedef logic [COUNT_BITS-1:0]        count_t;

    typedef struct packed {
        logic   kind;
        slot_t  slot;
        coord_t center_x;
        coord_t center_y;
        coord_t center_z;
        size_t  size_x;
        size_t  size_y;
        size_t  size_z;
        coord_t move_x;
        coord_t move_y;
        coord_t move_z;
    } in_item_t;

    typedef struct packed {
        logic  hit;
        slot_t hit_index;
    } out_item_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } ctr_word_t;

    typedef struct packed {
        size_t z;
        size_t y;
        size_t x;
    } size_word_t;

    // Result handed from the scanner to the output register.
    typedef struct packed {
        logic  valid;
        logic  hit;
        slot_t index;
    } scan_res_t;

    function automatic bound_t sx(input coord_t c);
        return {{(BND_BITS-COORD_BITS){c[COORD_BITS-1]}}, c};
    endfunction

    function automatic bound_t zx(input size_t s);
        return {{(BND_BITS-SIZE_BITS){1'b0}}, s};
    endfunction

    // Doubled centre minus / plus full size: exact interval ends at twice scale.
    function automatic bound_t bnd_lo(input bound_t c, input size_t s);
        return (c <<< 1) - zx(s);
    endfunction

    function automatic bound_t bnd_hi(input bound_t c, input size_t s);
        return (c <<< 1) + zx(s);
    endfunction

    function automatic logic axis_hit(input bound_t qlo, input bound_t qhi,
                                      input coord_t c, input size_t s);
        bound_t olo;
        bound_t ohi;
        olo = bnd_lo(sx(c), s);
        ohi = bnd_hi(sx(c), s);
        return (qlo <= ohi) && (qhi >= olo);
    endfunction

endpackage

`default_nettype wire

// ===== design/bofh_ram.sv =====
`default_nettype none

module bofh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/bofh_scan.sv =====
`default_nettype none

module bofh_scan #(
    parameter int MAX_OBSTACLES = 64,
    localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1,
    localparam int CW = $clog2(MAX_OBSTACLES + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire bofh_pkg::in_item_t   query,
    input  wire bofh_pkg::count_t     count,
    input  wire bofh_pkg::ctr_word_t  ctr_rd,
    input  wire bofh_pkg::size_word_t sz_rd,
    input  wire logic                 res_take,
    output logic                      rd_en,
    output logic [AW-1:0]             rd_addr,
    output logic                      busy,
    output bofh_pkg::scan_res_t       res
);

    import bofh_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          hit_reg, hit_next;
    slot_t         idx_reg, idx_next;
    bound_t        qlo_reg [3];
    bound_t        qhi_reg [3];

    bound_t        mc [3];
    logic          ovl;

    // Moved box centre, one wide add per axis.
    assign mc[0] = sx(query.center_x) + sx(query.move_x);
    assign mc[1] = sx(query.center_y) + sx(query.move_y);
    assign mc[2] = sx(query.center_z) + sx(query.move_z);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qlo_reg[0] <= bnd_lo(mc[0], query.size_x);
            qhi_reg[0] <= bnd_hi(mc[0], query.size_x);
            qlo_reg[1] <= bnd_lo(mc[1], query.size_y);
            qhi_reg[1] <= bnd_hi(mc[1], query.size_y);
            qlo_reg[2] <= bnd_lo(mc[2], query.size_z);
            qhi_reg[2] <= bnd_hi(mc[2], query.size_z);
        end
    end

    assign ovl = axis_hit(qlo_reg[0], qhi_reg[0], ctr_rd.x, sz_rd.x)
              && axis_hit(qlo_reg[1], qhi_reg[1], ctr_rd.y, sz_rd.y)
              && axis_hit(qlo_reg[2], qhi_reg[2], ctr_rd.z, sz_rd.z);

    assign rd_en   = (state_reg == S_SCAN) && (issue_reg < limit_reg);
    assign rd_addr = issue_reg[AW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        issue_next   = issue_reg;
        limit_next   = limit_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        hit_next     = hit_reg;
        idx_next     = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // Saturate the count to the table depth.
                    if (32'(count) > MAX_OBSTACLES)
                    begin
                        limit_next = CW'(MAX_OBSTACLES);
                    end
                    else
                    begin
                        limit_next = CW'(count);
                    end
                    issue_next = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cmp_vld_reg && ovl)
                begin
                    hit_next   = 1'b1;
                    idx_next   = SLOT_BITS'(cmp_idx_reg);
                    state_next = S_DONE;
                end
                else if (issue_reg >= limit_reg)
                begin
                    hit_next   = 1'b0;
                    idx_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg;
                    issue_next   = issue_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            issue_reg   <= '0;
            limit_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
            hit_reg     <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            limit_reg   <= limit_next;
            cmp_vld_reg <= cmp_vld_next;
            cmp_idx_reg <= cmp_idx_next;
            hit_reg     <= hit_next;
            idx_reg     <= idx_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign res.valid = (state_reg == S_DONE);
    assign res.hit   = hit_reg;
    assign res.index = idx_reg;

endmodule

`default_nettype wire

// ===== design/box_obstacle_first_hit_search.sv =====
`default_nettype none

// First-hit search of a moving axis-aligned box against a table of obstacle
// boxes. A load item (kind 0) writes centre and size into table entry slot in
// the accepting cycle and gives no result; a slot at or beyond MAX_OBSTACLES
// is dropped. A query item (kind 1) shifts its box by the displacement, then
// tests entries 0 to obstacle_count-1 (saturated to MAX_OBSTACLES) in order
// and returns one result: hit and the lowest overlapping index, or hit 0 with
// index 0. Overlap is inclusive on every axis and computed on doubled
// coordinates, so touching boxes hit. Entries must be written before a query
// reaches them. A query holds in_stall until its result moves into the output
// register, and longer while the previous result still waits in a stalled
// output register. The result lands in the output register at the edge that
// ends the stall. The obstacle table sits in two synchronous memories,
// centres and sizes, read together one entry per cycle through a registered
// read port, and each entry is compared in the cycle after its read. The
// output register lets the next item in while a result waits on out_stall.
// Write obstacle_count only while no query is in flight.
module box_obstacle_first_hit_search #(
    parameter int MAX_OBSTACLES = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire bofh_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output bofh_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire bofh_pkg::count_t    cfg_data
);

    import bofh_pkg::*;

    localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

    logic       in_acc;
    logic       load_we;
    logic       start;
    logic       busy;
    logic       rd_en;
    logic [AW-1:0] rd_addr;
    ctr_word_t  ctr_wr;
    ctr_word_t  ctr_rd;
    size_word_t sz_wr;
    size_word_t sz_rd;
    scan_res_t  res;
    logic       res_take;

    count_t     count_reg;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg;

    // Configuration: always ready, one register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    // Hold off new items while a query scans the table or its result waits to move out.
    assign in_stall = busy;
    assign in_acc   = in_valid && !in_stall;
    assign load_we  = in_acc && (in_data.kind == KIND_LOAD)
                   && (32'(in_data.slot) < MAX_OBSTACLES);
    assign start    = in_acc && (in_data.kind == KIND_QUERY);

    assign ctr_wr.x = in_data.center_x;
    assign ctr_wr.y = in_data.center_y;
    assign ctr_wr.z = in_data.center_z;
    assign sz_wr.x  = in_data.size_x;
    assign sz_wr.y  = in_data.size_y;
    assign sz_wr.z  = in_data.size_z;

    bofh_ram #(
        .WIDTH ($bits(ctr_word_t)),
        .DEPTH (MAX_OBSTACLES)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(in_data.slot)),
        .wdata (ctr_wr),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ctr_rd)
    );

    bofh_ram #(
        .WIDTH ($bits(size_word_t)),
        .DEPTH (MAX_OBSTACLES)
    ) u_sz_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(in_data.slot)),
        .wdata (sz_wr),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (sz_rd)
    );

    bofh_scan #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .query    (in_data),
        .count    (count_reg),
        .ctr_rd   (ctr_rd),
        .sz_rd    (sz_rd),
        .res_take (res_take),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .busy     (busy),
        .res      (res)
    );

    // Move the finished result into the output register once it is free.
    assign res_take = res.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg.hit       <= res.hit;
            out_reg.hit_index <= res.index;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // A query always starts a scan.
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("query accepted but scanner stayed idle");

    // A miss carries index zero.
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.hit) |-> (out_data.hit_index == '0))
        else $error("miss result with nonzero index");

    // A new result only follows a finished scan.
    a_out_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(res.valid))
        else $error("result appeared without a finished scan");

    // Loads never land in the table during a scan.
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !load_we)
        else $error("table write during scan");

endmodule

`default_nettype wire
